### rtl/rclc_pkg.sv
// ----------------------------------------------------------------------------
// rclc_pkg
// Shared types, constants and helper functions of the channel light
// classifier.
// ----------------------------------------------------------------------------
package rclc_pkg;

  localparam int DEMO_ENABLE  = 1;
  localparam int CHANNEL_BITS = 12;
  localparam int DEMO_W       = CHANNEL_BITS + 1;
  localparam int BAND_W       = 11;
  localparam int TIME_W       = 32;
  localparam int STEP_W       = 5;
  localparam int CMP_W        = DEMO_W + 1;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 5;

  localparam logic [CHANNEL_BITS-1:0] RST_MIDPOINT  = CHANNEL_BITS'(1500);
  localparam logic [CHANNEL_BITS-1:0] RST_LOW       = CHANNEL_BITS'(1000);
  localparam logic [CHANNEL_BITS-1:0] RST_HIGH      = CHANNEL_BITS'(2000);
  localparam logic [BAND_W-1:0]       RST_BAND      = BAND_W'(100);
  localparam logic [TIME_W-1:0]       RST_DEMO_TMO  = TIME_W'(10000);
  localparam logic [TIME_W-1:0]       RST_FLASH_TMO = TIME_W'(1000);
  localparam logic [CHANNEL_BITS-1:0] DEMO_START_ENABLE = CHANNEL_BITS'(1000);

  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(15);

  // Light levels.
  localparam logic [1:0] LEVEL_LOW  = 2'd0;
  localparam logic [1:0] LEVEL_MID  = 2'd1;
  localparam logic [1:0] LEVEL_HIGH = 2'd2;

  typedef enum logic [2:0] {
    REG_MIDPOINT  = 3'd0,
    REG_LOW       = 3'd1,
    REG_HIGH      = 3'd2,
    REG_LEVEL_BND = 3'd3,
    REG_TURN_BND  = 3'd4,
    REG_BRAKE_BND = 3'd5,
    REG_DEMO_TMO  = 3'd6,
    REG_FLASH_TMO = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_LOAD,
    PH_STEER_UP,
    PH_STEER_DOWN,
    PH_THR_UP,
    PH_THR_DOWN,
    PH_LEVEL,
    PH_HOLD
  } demo_phase_t;

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] midpoint;
    logic [CHANNEL_BITS-1:0] low;
    logic [CHANNEL_BITS-1:0] high;
    logic [BAND_W-1:0]       level_band;
    logic [BAND_W-1:0]       turn_band;
    logic [BAND_W-1:0]       brake_band;
    logic [TIME_W-1:0]       demo_timeout;
    logic [TIME_W-1:0]       flash_timeout;
  } cfg_t;

  typedef struct packed {
    logic [DEMO_W-1:0] steer;
    logic [DEMO_W-1:0] throttle;
    logic [DEMO_W-1:0] level;
    logic [DEMO_W-1:0] enable;
  } channels_t;

  typedef struct packed {
    logic       hazards_on;
    logic       brake_on;
    logic       turn_right;
    logic       turn_left;
    logic [1:0] light_level;
    logic       lights_enabled;
  } flags_t;

  // Sweep phase for a step count; the cycle of five phases repeats three times.
  function automatic demo_phase_t demo_phase(input logic [STEP_W-1:0] step);
    demo_phase_t ph;
    begin
      ph = PH_HOLD;
      case (step)
        STEP_W'(0): ph = PH_LOAD;
        STEP_W'(1), STEP_W'(6), STEP_W'(11):  ph = PH_STEER_UP;
        STEP_W'(2), STEP_W'(7), STEP_W'(12):  ph = PH_STEER_DOWN;
        STEP_W'(3), STEP_W'(8), STEP_W'(13):  ph = PH_THR_UP;
        STEP_W'(4), STEP_W'(9), STEP_W'(14):  ph = PH_THR_DOWN;
        STEP_W'(5), STEP_W'(10), STEP_W'(15): ph = PH_LEVEL;
        default: ph = PH_HOLD;
      endcase
      return ph;
    end
  endfunction

endpackage

### rtl/rclc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rclc_cfg_regs
// APB-style register bank holding thresholds and timeouts.
// ----------------------------------------------------------------------------
module rclc_cfg_regs
  import rclc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MIDPOINT:  cfg_nxt.midpoint      = cfg_pwdata[CHANNEL_BITS-1:0];
        REG_LOW:       cfg_nxt.low           = cfg_pwdata[CHANNEL_BITS-1:0];
        REG_HIGH:      cfg_nxt.high          = cfg_pwdata[CHANNEL_BITS-1:0];
        REG_LEVEL_BND: cfg_nxt.level_band    = cfg_pwdata[BAND_W-1:0];
        REG_TURN_BND:  cfg_nxt.turn_band     = cfg_pwdata[BAND_W-1:0];
        REG_BRAKE_BND: cfg_nxt.brake_band    = cfg_pwdata[BAND_W-1:0];
        REG_DEMO_TMO:  cfg_nxt.demo_timeout  = cfg_pwdata[TIME_W-1:0];
        REG_FLASH_TMO: cfg_nxt.flash_timeout = cfg_pwdata[TIME_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIDPOINT:  cfg_prdata = CFG_DATA_W'(cfg_r.midpoint);
      REG_LOW:       cfg_prdata = CFG_DATA_W'(cfg_r.low);
      REG_HIGH:      cfg_prdata = CFG_DATA_W'(cfg_r.high);
      REG_LEVEL_BND: cfg_prdata = CFG_DATA_W'(cfg_r.level_band);
      REG_TURN_BND:  cfg_prdata = CFG_DATA_W'(cfg_r.turn_band);
      REG_BRAKE_BND: cfg_prdata = CFG_DATA_W'(cfg_r.brake_band);
      REG_DEMO_TMO:  cfg_prdata = CFG_DATA_W'(cfg_r.demo_timeout);
      REG_FLASH_TMO: cfg_prdata = CFG_DATA_W'(cfg_r.flash_timeout);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.midpoint      <= RST_MIDPOINT;
      cfg_r.low           <= RST_LOW;
      cfg_r.high          <= RST_HIGH;
      cfg_r.level_band    <= RST_BAND;
      cfg_r.turn_band     <= RST_BAND;
      cfg_r.brake_band    <= RST_BAND;
      cfg_r.demo_timeout  <= RST_DEMO_TMO;
      cfg_r.flash_timeout <= RST_FLASH_TMO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### rtl/rclc_demo.sv
// ----------------------------------------------------------------------------
// rclc_demo
// Sweep generator that produces synthetic channels while the radio is silent.
// ----------------------------------------------------------------------------
module rclc_demo
  import rclc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  cfg_t      cfg,
  output channels_t demo_nxt
);

  logic [DEMO_W-1:0]       steer_r, steer_nxt;
  logic [DEMO_W-1:0]       thr_r, thr_nxt;
  logic [DEMO_W-1:0]       level_r, level_nxt;
  logic [CHANNEL_BITS-1:0] enable_r, enable_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic [DEMO_W-1:0]       high_x, low_x, level_sum;
  demo_phase_t             phase;

  assign high_x    = {1'b0, cfg.high};
  assign low_x     = {1'b0, cfg.low};
  assign level_sum = level_r + {1'b0, cfg.midpoint};
  assign phase     = demo_phase(step_r);

  always_comb begin
    steer_nxt  = steer_r;
    thr_nxt    = thr_r;
    level_nxt  = level_r;
    enable_nxt = enable_r;
    step_nxt   = step_r;
    unique case (phase)
      PH_LOAD: begin
        enable_nxt = DEMO_START_ENABLE;
        level_nxt  = '0;
        steer_nxt  = '0;
        thr_nxt    = '0;
        step_nxt   = STEP_W'(1);
      end
      PH_STEER_UP: begin
        if (steer_r >= high_x) begin
          steer_nxt = high_x;
          step_nxt  = step_r + 1'b1;
        end else begin
          steer_nxt = steer_r + 1'b1;
        end
      end
      PH_STEER_DOWN: begin
        if (steer_r <= low_x) begin
          steer_nxt = low_x;
          step_nxt  = step_r + 1'b1;
        end else begin
          steer_nxt = steer_r - 1'b1;
        end
      end
      PH_THR_UP: begin
        if (thr_r >= high_x) begin
          thr_nxt  = high_x;
          step_nxt = step_r + 1'b1;
        end else begin
          thr_nxt = thr_r + 1'b1;
        end
      end
      PH_THR_DOWN: begin
        if (thr_r <= low_x) begin
          thr_nxt  = low_x;
          step_nxt = step_r + 1'b1;
        end else begin
          thr_nxt = thr_r - 1'b1;
        end
      end
      PH_LEVEL: begin
        // Once the level passes the ceiling the whole sweep starts over.
        if (level_sum > high_x) begin
          level_nxt = low_x;
          step_nxt  = '0;
        end else begin
          level_nxt = level_sum;
          step_nxt  = step_r + 1'b1;
        end
      end
      PH_HOLD: begin
        step_nxt = step_r;
      end
      default: begin
        step_nxt = step_r;
      end
    endcase
  end

  assign demo_nxt.steer    = steer_nxt;
  assign demo_nxt.throttle = thr_nxt;
  assign demo_nxt.level    = level_nxt;
  assign demo_nxt.enable   = {1'b0, enable_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_r  <= {1'b0, RST_MIDPOINT};
      thr_r    <= {1'b0, RST_MIDPOINT};
      level_r  <= '0;
      enable_r <= RST_HIGH;
      step_r   <= '0;
    end else if (advance) begin
      steer_r  <= steer_nxt;
      thr_r    <= thr_nxt;
      level_r  <= level_nxt;
      enable_r <= enable_nxt;
      step_r   <= step_nxt;
    end
  end

endmodule

### rtl/rclc_classify.sv
// ----------------------------------------------------------------------------
// rclc_classify
// Compares four channels against the midpoint and bands to form light flags.
// ----------------------------------------------------------------------------
module rclc_classify
  import rclc_pkg::*;
(
  input  channels_t ch,
  input  cfg_t      cfg,
  output flags_t    flags
);

  logic [CMP_W-1:0] mid;
  logic [CMP_W-1:0] mid_plus_lb, mid_plus_tb;
  logic [CMP_W-1:0] lvl_plus_lb, str_plus_tb, thr_plus_bb;

  // "x < mid - band" is tested as "x + band < mid" so no value goes negative.
  assign mid         = CMP_W'(cfg.midpoint);
  assign mid_plus_lb = mid + CMP_W'(cfg.level_band);
  assign mid_plus_tb = mid + CMP_W'(cfg.turn_band);
  assign lvl_plus_lb = CMP_W'(ch.level) + CMP_W'(cfg.level_band);
  assign str_plus_tb = CMP_W'(ch.steer) + CMP_W'(cfg.turn_band);
  assign thr_plus_bb = CMP_W'(ch.throttle) + CMP_W'(cfg.brake_band);

  always_comb begin
    flags.lights_enabled = CMP_W'(ch.enable) > mid_plus_lb;
    if (lvl_plus_lb < mid) begin
      flags.light_level = LEVEL_LOW;
    end else if (CMP_W'(ch.level) > mid_plus_lb) begin
      flags.light_level = LEVEL_HIGH;
    end else begin
      flags.light_level = LEVEL_MID;
    end
    flags.turn_left  = str_plus_tb < mid;
    flags.turn_right = CMP_W'(ch.steer) > mid_plus_tb;
    flags.brake_on   = thr_plus_bb < mid;
    flags.hazards_on = 1'b0;
  end

endmodule

### rtl/rc_channel_light_classifier.sv
// ----------------------------------------------------------------------------
// rc_channel_light_classifier
// Classifies radio-control channel samples into light flags, with hazard
// timing and a demo sweep when the radio falls silent.
// ----------------------------------------------------------------------------
// Each item passes the input register, then the result register, and waits
// in the input register while the output is stalled. Throughput: one item
// per cycle while the output is not stalled; the held state and the sweep
// update in the same cycle the item moves into the result register.
// Reset: synchronous, active low; clears the pipeline and flags, presets the
// held channels and sweep generator and loads the default register values.
module rc_channel_light_classifier
  import rclc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] steer_value, [23:12] throttle_value, [35:24] level_value,
  // [47:36] enable_value, [79:48] sample_time_ms, [111:80] now_ms
  input  logic [111:0]          in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] lights_enabled, [2:1] light_level, [3] turn_left, [4] turn_right,
  // [5] brake_on, [6] hazards_on, [7] zero
  output logic [7:0]            out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t cfg;

  // Input stage.
  logic                    s1_valid_r;
  logic [CHANNEL_BITS-1:0] s1_steer_r, s1_thr_r, s1_level_r, s1_enable_r;
  logic [TIME_W-1:0]       s1_stime_r, s1_now_r;

  // Held state and result stage.
  logic [CHANNEL_BITS-1:0] held_steer_r, held_thr_r, held_level_r, held_enable_r;
  logic [TIME_W-1:0]       held_time_r;
  flags_t                  flags_r, flags_nxt;
  logic                    out_valid_r;

  logic                    out_free, advance;
  logic                    demo_mode, same, flash_expired;
  logic [TIME_W-1:0]       radio_age, held_age;
  channels_t               demo_nxt, sample_ch, class_ch;
  flags_t                  class_flags;

  rclc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  assign radio_age     = s1_now_r - s1_stime_r;
  assign held_age      = s1_now_r - held_time_r;
  assign demo_mode     = (DEMO_ENABLE != 0) && (radio_age > cfg.demo_timeout);
  assign flash_expired = held_age > cfg.flash_timeout;
  assign same          = (s1_steer_r == held_steer_r) && (s1_thr_r == held_thr_r) &&
                         (s1_level_r == held_level_r) && (s1_enable_r == held_enable_r);

  assign sample_ch.steer    = {1'b0, s1_steer_r};
  assign sample_ch.throttle = {1'b0, s1_thr_r};
  assign sample_ch.level    = {1'b0, s1_level_r};
  assign sample_ch.enable   = {1'b0, s1_enable_r};

  rclc_demo u_demo (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance && demo_mode),
    .cfg      (cfg),
    .demo_nxt (demo_nxt)
  );

  assign class_ch = demo_mode ? demo_nxt : sample_ch;

  rclc_classify u_classify (
    .ch    (class_ch),
    .cfg   (cfg),
    .flags (class_flags)
  );

  always_comb begin
    priority if (demo_mode) begin
      flags_nxt = class_flags;
    end else if (same) begin
      // An unchanged sample keeps the flags and can only raise hazards.
      flags_nxt            = flags_r;
      flags_nxt.hazards_on = flags_r.hazards_on | flash_expired;
    end else begin
      flags_nxt = class_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_steer_r  <= in_tdata[11:0];
      s1_thr_r    <= in_tdata[23:12];
      s1_level_r  <= in_tdata[35:24];
      s1_enable_r <= in_tdata[47:36];
      s1_stime_r  <= in_tdata[79:48];
      s1_now_r    <= in_tdata[111:80];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      flags_r       <= '0;
      held_steer_r  <= RST_MIDPOINT;
      held_thr_r    <= RST_MIDPOINT;
      held_level_r  <= '0;
      held_enable_r <= RST_HIGH;
      held_time_r   <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        flags_r <= flags_nxt;
        if (!demo_mode && !same) begin
          held_steer_r  <= s1_steer_r;
          held_thr_r    <= s1_thr_r;
          held_level_r  <= s1_level_r;
          held_enable_r <= s1_enable_r;
          held_time_r   <= s1_stime_r;
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, flags_r};

  a_demo_clears_hazards: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && demo_mode) |=> !flags_r.hazards_on)
    else $error("hazards set after a demo step");

  a_no_both_turns: assert property (@(posedge clk) disable iff (!rst_n)
    !(flags_r.turn_left && flags_r.turn_right))
    else $error("left and right turn flags both set");

  a_level_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (flags_r.light_level == LEVEL_LOW || flags_r.light_level == LEVEL_MID ||
                     flags_r.light_level == LEVEL_HIGH))
    else $error("light level code out of range");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("input stalled without a full pipeline");

endmodule

### sim/tb_rc_channel_light_classifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_channel_light_classifier
// Drives channel samples into the light classifier over its input stream,
// predicts the light flags, including the hazard timer and the demo sweep,
// and compares every result item field by field. The register bank is
// reloaded between phases, from near the reset values through both extremes.
// ----------------------------------------------------------------------------
module tb_rc_channel_light_classifier;
  import rclc_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int ITEMS_PER_SET = 140;

  // Laid out exactly like in_tdata, steer in the lowest bits.
  typedef struct packed {
    logic [TIME_W-1:0]       now_ms;
    logic [TIME_W-1:0]       sample_time_ms;
    logic [CHANNEL_BITS-1:0] enable_value;
    logic [CHANNEL_BITS-1:0] level_value;
    logic [CHANNEL_BITS-1:0] throttle_value;
    logic [CHANNEL_BITS-1:0] steer_value;
  } sample_t;

  typedef struct {
    sample_t s;
    logic    typed;
    flags_t  want;
  } script_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  // [11:0] steer_value, [23:12] throttle_value, [35:24] level_value,
  // [47:36] enable_value, [79:48] sample_time_ms, [111:80] now_ms
  logic [111:0]          in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  // [0] lights_enabled, [2:1] light_level, [3] turn_left, [4] turn_right,
  // [5] brake_on, [6] hazards_on, [7] zero
  logic [7:0]            out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Predictor state.
  cfg_t              cfg;
  logic [11:0]       held_steer, held_thr, held_lvl, held_en;
  logic [31:0]       held_time;
  logic [STEP_W-1:0] sweep_step;
  logic [DEMO_W-1:0] sweep_steer, sweep_thr, sweep_lvl;
  logic [11:0]       sweep_en;
  flags_t            lamps;
  flags_t            flags_due[$];

  // Stimulus bookkeeping: the last sample the block has stored.
  sample_t     gen_last;
  logic [31:0] gen_time;
  logic [31:0] clock_ms;

  // Typed expectation travelling with a directed item.
  logic   script_typed;
  flags_t script_want;

  int fail_count  = 0;
  int cycle_count = 0;
  int result_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_off_go   = 1'b0;
  logic hold_off_done = 1'b0;

  script_row_t script [20];
  cfg_t        setups [5];

  rc_channel_light_classifier uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic void classify_into(input int steer, input int thr, input int lvl,
                                        input int en);
    int mid, lband;
    mid   = int'(cfg.midpoint);
    lband = int'(cfg.level_band);
    lamps.lights_enabled = (en > mid + lband);
    if (lvl < mid - lband) begin
      lamps.light_level = LEVEL_LOW;
    end else if (lvl > mid + lband) begin
      lamps.light_level = LEVEL_HIGH;
    end else begin
      lamps.light_level = LEVEL_MID;
    end
    // A threshold below zero simply leaves the flag clear.
    lamps.turn_left  = (steer < mid - int'(cfg.turn_band));
    lamps.turn_right = (steer > mid + int'(cfg.turn_band));
    lamps.brake_on   = (thr < mid - int'(cfg.brake_band));
  endfunction

  // A ramp that reaches its end holds there and moves the sweep on.
  function automatic logic [DEMO_W-1:0] ramp_up(input logic [DEMO_W-1:0] v);
    if (v >= DEMO_W'(cfg.high)) begin
      sweep_step = sweep_step + 1'b1;
      return DEMO_W'(cfg.high);
    end
    return v + 1'b1;
  endfunction

  function automatic logic [DEMO_W-1:0] ramp_down(input logic [DEMO_W-1:0] v);
    if (v <= DEMO_W'(cfg.low)) begin
      sweep_step = sweep_step + 1'b1;
      return DEMO_W'(cfg.low);
    end
    return v - 1'b1;
  endfunction

  function automatic void advance_sweep();
    demo_phase_t ph;
    if (sweep_step == '0) begin
      sweep_en    = DEMO_START_ENABLE;
      sweep_lvl   = '0;
      sweep_steer = '0;
      sweep_thr   = '0;
      sweep_step  = STEP_W'(1);
    end else if (sweep_step <= STEP_LAST) begin
      // Five phases repeat three times; past the last step nothing moves.
      ph = demo_phase_t'(int'(PH_STEER_UP) + (int'(sweep_step) - 1) % 5);
      case (ph)
        PH_STEER_UP:   sweep_steer = ramp_up(sweep_steer);
        PH_STEER_DOWN: sweep_steer = ramp_down(sweep_steer);
        PH_THR_UP:     sweep_thr = ramp_up(sweep_thr);
        PH_THR_DOWN:   sweep_thr = ramp_down(sweep_thr);
        PH_LEVEL: begin
          sweep_lvl  = sweep_lvl + DEMO_W'(cfg.midpoint);
          sweep_step = sweep_step + 1'b1;
          if (sweep_lvl > DEMO_W'(cfg.high)) begin
            sweep_lvl  = DEMO_W'(cfg.low);
            sweep_step = '0;
          end
        end
        default: ;
      endcase
    end
  endfunction

  function automatic flags_t next_flags(input sample_t s);
    logic [31:0] radio_age, still_age;
    radio_age = s.now_ms - s.sample_time_ms;
    still_age = s.now_ms - held_time;
    if (DEMO_ENABLE != 0 && radio_age > cfg.demo_timeout) begin
      lamps.hazards_on = 1'b0;
      advance_sweep();
      classify_into(int'(sweep_steer), int'(sweep_thr), int'(sweep_lvl), int'(sweep_en));
    end else if (s.steer_value == held_steer && s.throttle_value == held_thr &&
                 s.level_value == held_lvl && s.enable_value == held_en) begin
      if (still_age > cfg.flash_timeout) lamps.hazards_on = 1'b1;
    end else begin
      held_steer = s.steer_value;
      held_thr   = s.throttle_value;
      held_lvl   = s.level_value;
      held_en    = s.enable_value;
      held_time  = s.sample_time_ms;
      lamps.hazards_on = 1'b0;
      classify_into(int'(s.steer_value), int'(s.throttle_value), int'(s.level_value),
                    int'(s.enable_value));
    end
    return lamps;
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic compare_field(input string name, input logic [1:0] want,
                               input logic [1:0] got);
    if (got !== want) begin
      $display("%0t ns: result %0d %s expected %0d, got %0d", $time, result_count, name,
               want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    sample_t taken;
    flags_t  fresh, want, got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        taken = in_tdata;
        fresh = next_flags(taken);
        flags_due.push_back(script_typed ? script_want : fresh);
      end
      if (out_tvalid && out_tready) begin
        if (flags_due.size() == 0) begin
          $display("%0t ns: result %0d arrived with nothing expected, got %h", $time,
                   result_count, out_tdata);
          fail_count++;
        end else begin
          want = flags_due.pop_front();
          got  = flags_t'(out_tdata[6:0]);
          compare_field("lights_enabled", want.lights_enabled, got.lights_enabled);
          compare_field("light_level", want.light_level, got.light_level);
          compare_field("turn_left", want.turn_left, got.turn_left);
          compare_field("turn_right", want.turn_right, got.turn_right);
          compare_field("brake_on", want.brake_on, got.brake_on);
          compare_field("hazards_on", want.hazards_on, got.hazards_on);
          compare_field("pad bit", 2'd0, {1'b0, out_tdata[7]});
        end
        result_count++;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : receiver
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_go && !hold_off_done) begin
        // Long back-pressure so the pipeline fills and stalls its input.
        out_tready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_off_done = 1'b1;
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic flags_t flags_of(input logic en, input logic [1:0] lvl, input logic l,
                                      input logic r, input logic b, input logic h);
    return '{hazards_on: h, brake_on: b, turn_right: r, turn_left: l, light_level: lvl,
             lights_enabled: en};
  endfunction

  function automatic sample_t smp(input int steer, input int thr, input int lvl, input int en,
                                  input logic [31:0] stime, input logic [31:0] now);
    return '{now_ms: now, sample_time_ms: stime, enable_value: 12'(en),
             level_value: 12'(lvl), throttle_value: 12'(thr), steer_value: 12'(steer)};
  endfunction

  function automatic logic [31:0] cap(input logic [31:0] a, input logic [31:0] b);
    return (a < b) ? a : b;
  endfunction

  // Mostly values right around a threshold, plus the extremes and noise.
  function automatic logic [11:0] pick_channel(input int band);
    int v;
    case ($urandom_range(0, 9))
      0:       v = 0;
      1:       v = 4095;
      2, 3:    v = $urandom_range(0, 4095);
      default: v = int'(cfg.midpoint) + ($urandom_range(0, 1) ? band : -band) +
                   int'($urandom_range(0, 4)) - 2;
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic sample_t pick_sample();
    sample_t         s;
    int              kind;
    longint unsigned room, extra;
    logic [31:0]     age;
    s    = gen_last;
    kind = $urandom_range(0, 99);
    clock_ms = clock_ms + $urandom_range(0, 400);
    if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
    if (kind < 15 && cfg.demo_timeout != '1) begin
      // Radio silent past the demo timeout; the channels are noise.
      room  = 64'hFFFF_FFFF - longint'(cfg.demo_timeout) - 1;
      extra = (room > 1000) ? $urandom_range(0, 1000) : $urandom_range(0, 32'(room));
      if ($urandom_range(0, 7) == 0) extra = longint'($urandom) % (room + 1);
      s = smp($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095),
              $urandom_range(0, 4095), '0, clock_ms);
      s.sample_time_ms = clock_ms - 32'(longint'(cfg.demo_timeout) + 1 + extra);
    end else if (kind < 45) begin
      // Same channels again, aged either side of the flash timeout.
      if ($urandom_range(0, 1) && cfg.flash_timeout != '1) begin
        age = cfg.flash_timeout + $urandom_range(1, 3);
      end else begin
        age = $urandom_range(0, cfg.flash_timeout);
      end
      s.now_ms = gen_time + age;
      s.sample_time_ms = s.now_ms - $urandom_range(0, cap(cfg.demo_timeout, 2000));
    end else begin
      if (kind < 70) begin
        case ($urandom_range(0, 3))
          0: s.steer_value = $urandom_range(0, 1) ? s.steer_value + 1'b1
                                                  : pick_channel(cfg.turn_band);
          1: s.throttle_value = $urandom_range(0, 1) ? s.throttle_value - 1'b1
                                                     : pick_channel(cfg.brake_band);
          2: s.level_value = pick_channel(cfg.level_band);
          default: s.enable_value = pick_channel(cfg.level_band);
        endcase
      end else begin
        s.steer_value    = pick_channel(cfg.turn_band);
        s.throttle_value = pick_channel(cfg.brake_band);
        s.level_value    = pick_channel(cfg.level_band);
        s.enable_value   = pick_channel(cfg.level_band);
      end
      s.now_ms = clock_ms;
      s.sample_time_ms = clock_ms - $urandom_range(0, cap(cfg.demo_timeout, 3000));
    end
    return s;
  endfunction

  task automatic offer(input sample_t s, input logic typed, input flags_t want);
    logic [31:0] radio_age;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid    <= 1'b1;
    in_tdata     <= s;
    script_typed <= typed;
    script_want  <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    radio_age = s.now_ms - s.sample_time_ms;
    if (radio_age <= cfg.demo_timeout &&
        (s.steer_value != gen_last.steer_value || s.throttle_value != gen_last.throttle_value ||
         s.level_value != gen_last.level_value || s.enable_value != gen_last.enable_value)) begin
      gen_last = s;
      gen_time = s.sample_time_ms;
    end
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (flags_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] mask, kept, readback;
    case (idx)
      REG_MIDPOINT, REG_LOW, REG_HIGH:           mask = 32'hFFF;
      REG_LEVEL_BND, REG_TURN_BND, REG_BRAKE_BND: mask = 32'h7FF;
      default:                                    mask = '1;
    endcase
    kept = value & mask;
    case (idx)
      REG_MIDPOINT:  cfg.midpoint      = kept[11:0];
      REG_LOW:       cfg.low           = kept[11:0];
      REG_HIGH:      cfg.high          = kept[11:0];
      REG_LEVEL_BND: cfg.level_band    = kept[10:0];
      REG_TURN_BND:  cfg.turn_band     = kept[10:0];
      REG_BRAKE_BND: cfg.brake_band    = kept[10:0];
      REG_DEMO_TMO:  cfg.demo_timeout  = kept;
      default:       cfg.flash_timeout = kept;
    endcase
    // Bits above the register width are junk and must be dropped.
    apb_xfer(1'b1, idx, kept | ($urandom & ~mask), readback);
    apb_xfer(1'b0, idx, '0, readback);
    if (readback !== kept) begin
      $display("%0t ns: register %s read expected %h, got %h", $time, idx.name(), kept,
               readback);
      fail_count++;
    end
  endtask

  task automatic load_setup(input cfg_t c);
    set_reg(REG_MIDPOINT, 32'(c.midpoint));
    set_reg(REG_LOW, 32'(c.low));
    set_reg(REG_HIGH, 32'(c.high));
    set_reg(REG_LEVEL_BND, 32'(c.level_band));
    set_reg(REG_TURN_BND, 32'(c.turn_band));
    set_reg(REG_BRAKE_BND, 32'(c.brake_band));
    set_reg(REG_DEMO_TMO, c.demo_timeout);
    set_reg(REG_FLASH_TMO, c.flash_timeout);
  endtask

  initial begin : stimulus
    int i, p;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    script_typed = 1'b0;
    script_want  = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;

    cfg = '{RST_MIDPOINT, RST_LOW, RST_HIGH, RST_BAND, RST_BAND, RST_BAND, RST_DEMO_TMO,
            RST_FLASH_TMO};
    held_steer  = RST_MIDPOINT;
    held_thr    = RST_MIDPOINT;
    held_lvl    = '0;
    held_en     = RST_HIGH;
    held_time   = '0;
    sweep_step  = '0;
    sweep_steer = DEMO_W'(RST_MIDPOINT);
    sweep_thr   = DEMO_W'(RST_MIDPOINT);
    sweep_lvl   = '0;
    sweep_en    = RST_HIGH;
    lamps       = '0;
    gen_last    = smp(RST_MIDPOINT, RST_MIDPOINT, 0, RST_HIGH, '0, '0);
    gen_time    = '0;
    clock_ms    = 32'd20000;

    // Directed items; the typed rows assume the reset register values.
    script[0]  = '{smp(1500, 1500, 0, 2000, 0, 0), 1'b1, '0};
    script[1]  = '{smp(1500, 1500, 0, 2000, 1001, 1001), 1'b1,
                   flags_of(0, LEVEL_LOW, 0, 0, 0, 1)};
    script[2]  = '{smp(0, 0, 0, 0, 5, 5), 1'b1, flags_of(0, LEVEL_LOW, 1, 0, 1, 0)};
    script[3]  = '{smp(4095, 4095, 4095, 4095, 6, 6), 1'b1,
                   flags_of(1, LEVEL_HIGH, 0, 1, 0, 0)};
    script[4]  = '{smp(1500, 1500, 1500, 1500, 7, 7), 1'b1,
                   flags_of(0, LEVEL_MID, 0, 0, 0, 0)};
    script[5]  = '{smp(1400, 1400, 1400, 1600, 8, 8), 1'b0, '0};
    script[6]  = '{smp(1399, 1399, 1399, 1601, 9, 9), 1'b0, '0};
    script[7]  = '{smp(1601, 1600, 1601, 1600, 10, 10), 1'b0, '0};
    // First silent item loads the sweep: all channels low, enable at 1000.
    script[8]  = '{smp(1601, 1600, 1601, 1600, 0, 10011), 1'b1,
                   flags_of(0, LEVEL_LOW, 1, 0, 1, 0)};
    script[9]  = '{smp(1601, 1600, 1601, 1600, 0, 10012), 1'b0, '0};
    // Time stamps that wrap, then the flash timeout hit exactly and by one.
    script[10] = '{smp(1400, 1600, 1399, 1601, 32'hFFFF_FFF0, 32'h10), 1'b0, '0};
    script[11] = '{smp(1400, 1600, 1399, 1601, 32'h3D8, 32'h3D8), 1'b0, '0};
    script[12] = '{smp(1400, 1600, 1399, 1601, 32'h3D9, 32'h3D9), 1'b0, '0};
    // Demo timeout hit exactly, then by one; the held sample must survive.
    script[13] = '{smp(2000, 1000, 2000, 1000, 100, 10100), 1'b0, '0};
    script[14] = '{smp(2000, 1000, 2000, 1000, 100, 10101), 1'b0, '0};
    script[15] = '{smp(2000, 1000, 2000, 1000, 1200, 1200), 1'b0, '0};
    script[16] = '{smp(4095, 0, 4095, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0};
    script[17] = '{smp(4095, 0, 4095, 0, 0, 32'hFFFF_FFFF), 1'b0, '0};
    script[18] = '{smp(12'hAAA, 12'h555, 12'hAAA, 12'h555, 32'h5555_5555, 32'h5555_5555),
                   1'b0, '0};
    script[19] = '{smp(12'h555, 12'hAAA, 12'h555, 12'hAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA),
                   1'b0, '0};

    // Small highs keep the sweep short enough to run through; the last set
    // lets the sweep run past its final step and freeze.
    setups[0] = '{12'd1500, 12'd1000, 12'd2000, 11'd100, 11'd200, 11'd300, 32'd10000,
                  32'd1000};
    setups[1] = '{12'd12, 12'd3, 12'd20, 11'd4, 11'd5, 11'd6, 32'd500, 32'd50};
    setups[2] = '{12'd7, 12'd0, 12'd15, 11'd2047, 11'd1, 11'd0, 32'd1, 32'd123456};
    setups[3] = '{12'd4095, 12'd4095, 12'd4095, 11'd0, 11'd0, 11'd0, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF};
    setups[4] = '{12'd0, 12'd0, 12'd0, 11'd2047, 11'd2047, 11'd2047, 32'd0, 32'd0};

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 19;
    recv_idle_pct = 56;
    for (i = 0; i < 20; i++) offer(script[i].s, script[i].typed, script[i].want);
    settle();

    for (p = 0; p < 5; p++) begin
      load_setup(setups[p]);
      if (p == 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 19;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (p == 0) hold_off_go = 1'b1;
      repeat (ITEMS_PER_SET) offer(pick_sample(), 1'b0, '0);
      settle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### rc_channel_light_classifier.f
rtl/rclc_pkg.sv
rtl/rclc_cfg_regs.sv
rtl/rclc_demo.sv
rtl/rclc_classify.sv
rtl/rc_channel_light_classifier.sv
sim/tb_rc_channel_light_classifier.sv
